@@ rtl/core/tstp_pkg.sv @@
// Shared types and constants for the touch slot tracker and pacer.
// Depends on nothing; every other file in rtl/core imports it.
package tstp_pkg;

   localparam int TimeWidth  = 48;
   localparam int CoordWidth = 16;
   localparam int IdWidth    = 16;

   typedef enum logic [1:0] {
      FN_DOWN = 2'd0,
      FN_MOVE = 2'd1,
      FN_UP   = 2'd2,
      FN_RSVD = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_SENT    = 3'd0,
      ST_EXTRA   = 3'd1,
      ST_UNKNOWN = 3'd2,
      ST_FULL    = 3'd3,
      ST_REPEAT  = 3'd4
   } status_type;

   localparam logic [2:0] BTN_NONE   = 3'd0;
   localparam logic [2:0] BTN_PRESS  = 3'd1;
   localparam logic [2:0] BTN_KEEP   = 3'd4;
   localparam logic [2:0] BTN_SECOND = 3'd5;

   typedef logic [TimeWidth-1:0] time_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic eval;
      logic apply;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_last;
   } dp_stat_type;

endpackage

@@ rtl/core/tstp_if.sv @@
// Valid/ready channel interfaces for touch events and mouse results.
// Depends on tstp_pkg for the field widths.
interface tstp_req_if import tstp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [IdWidth-1:0]    pointer_id;
   logic [CoordWidth-1:0] pos_x;
   logic [CoordWidth-1:0] pos_y;
   logic [TimeWidth-1:0]  source_time;
   logic [TimeWidth-1:0]  local_time;

   modport source (output valid, func, pointer_id, pos_x, pos_y, source_time, local_time,
                   input ready);
   modport sink   (input valid, func, pointer_id, pos_x, pos_y, source_time, local_time,
                   output ready);
endinterface

interface tstp_rsp_if import tstp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CoordWidth-1:0] out_x;
   logic [CoordWidth-1:0] out_y;
   logic [2:0]            button_code;
   logic [TimeWidth-1:0]  delay_us;
   logic [2:0]            status;

   modport source (output valid, out_x, out_y, button_code, delay_us, status, input ready);
   modport sink   (input valid, out_x, out_y, button_code, delay_us, status, output ready);
endinterface

@@ rtl/core/tstp_ctrl.sv @@
// Sequencing state machine: accept, slot scan, offset, delay, commit.
// Depends on tstp_pkg for the command and status structs.
module tstp_ctrl import tstp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_EVAL   = 5'b00100,
      S_APPLY  = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the previous result has been transferred
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/tstp_datapath.sv @@
// Slot table, pacing times, offset and delay arithmetic, result register.
// Depends on tstp_pkg; driven by commands from tstp_ctrl.
module tstp_datapath import tstp_pkg::*; #(
   parameter int SLOTS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [1:0]            req_func,
   input  logic [IdWidth-1:0]    req_pointer_id,
   input  logic [CoordWidth-1:0] req_pos_x,
   input  logic [CoordWidth-1:0] req_pos_y,
   input  time_type              req_source_time,
   input  time_type              req_local_time,
   output logic [CoordWidth-1:0] rsp_out_x,
   output logic [CoordWidth-1:0] rsp_out_y,
   output logic [2:0]            rsp_button_code,
   output time_type              rsp_delay_us,
   output logic [2:0]            rsp_status
);

   localparam int IdxWidth = $clog2(SLOTS);
   localparam int CntWidth = $clog2(SLOTS + 1);

   // latched request
   func_type              func_ff;
   logic [IdWidth-1:0]    id_ff;
   logic [CoordWidth-1:0] x_ff, y_ff;
   time_type              src_ff, loc_ff;

   // scan results
   logic [IdxWidth-1:0]   idx_ff, hit_idx_ff, free_idx_ff;
   logic                  hit_ff, free_ok_ff;

   // slot table and pacing state
   logic [SLOTS-1:0]      busy_ff;
   logic [IdWidth-1:0]    slot_id_ff [SLOTS];
   logic [CntWidth-1:0]   count_ff;
   time_type              last_src_ff, last_loc_ff;

   // arithmetic pipeline
   time_type              src_off_ff, loc_off_ff, delay_ff;
   logic                  pace_off_ff;

   // result register
   logic [CoordWidth-1:0] out_x_ff, out_y_ff;
   logic [2:0]            out_btn_ff;
   time_type              out_delay_ff;
   status_type            out_status_ff;

   // commit decision
   status_type            st;
   logic [2:0]            btn;
   time_type              dly;
   logic                  claim, rel, upd_times, raw_times, clr_times;
   logic [CntWidth-1:0]   cnt_next;
   time_type              loc_paced;
   logic                  scan_match, scan_free;

   assign stat.scan_last = (idx_ff == IdxWidth'(SLOTS - 1));

   assign scan_match = busy_ff[idx_ff] && (slot_id_ff[idx_ff] == id_ff);
   assign scan_free  = !busy_ff[idx_ff];

   assign loc_paced = loc_ff + delay_ff;

   always_comb begin
      st        = ST_SENT;
      btn       = BTN_NONE;
      dly       = '0;
      claim     = 1'b0;
      rel       = 1'b0;
      upd_times = 1'b0;
      raw_times = 1'b0;
      clr_times = 1'b0;
      cnt_next  = count_ff;
      if (func_ff == FN_RSVD) begin
         st = ST_UNKNOWN;
      end else if (!hit_ff) begin
         if (func_ff != FN_DOWN) begin
            st = ST_UNKNOWN;
         end else if (!free_ok_ff) begin
            st = ST_FULL;
         end else begin
            claim     = 1'b1;
            raw_times = 1'b1;
            cnt_next  = count_ff + CntWidth'(1);
            if (cnt_next == CntWidth'(1))      btn = BTN_PRESS;
            else if (cnt_next == CntWidth'(2)) btn = BTN_SECOND;
            else                               st  = ST_EXTRA;
         end
      end else if (func_ff == FN_DOWN) begin
         st = ST_REPEAT;
      end else if (func_ff == FN_UP) begin
         rel = 1'b1;
         dly = delay_ff;
         if (count_ff != '0) cnt_next = count_ff - CntWidth'(1);
         if (cnt_next == '0) begin
            clr_times = 1'b1;
            btn       = BTN_NONE;
         end else if (cnt_next == CntWidth'(1)) begin
            upd_times = 1'b1;
            btn       = BTN_KEEP;
         end else begin
            st = ST_EXTRA;
         end
      end else begin
         upd_times = 1'b1;
         dly       = delay_ff;
         btn       = BTN_PRESS;
      end
   end

   // request latch and scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         id_ff   <= req_pointer_id;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         src_ff  <= req_source_time;
         loc_ff  <= req_local_time;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (scan_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (scan_free && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (!stat.scan_last) idx_ff <= idx_ff + IdxWidth'(1);
      end
   end

   // offsets, then delay
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         pace_off_ff <= (last_loc_ff == '0) || (last_src_ff == '0);
         src_off_ff  <= (src_ff > last_src_ff) ? src_ff - last_src_ff : '0;
         loc_off_ff  <= (loc_ff > last_loc_ff) ? loc_ff - last_loc_ff : '0;
      end
      if (cmd.apply) begin
         delay_ff <= (!pace_off_ff && (src_off_ff > loc_off_ff)) ?
                     src_off_ff - loc_off_ff : '0;
      end
   end

   // slot table contents carry no reset: an entry is only read while busy
   always_ff @(posedge clock) begin
      if (cmd.commit && claim) slot_id_ff[free_idx_ff] <= id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         count_ff    <= '0;
         last_src_ff <= '0;
         last_loc_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= cnt_next;
         if (claim) busy_ff[free_idx_ff] <= 1'b1;
         if (rel)   busy_ff[hit_idx_ff]  <= 1'b0;
         if (raw_times) begin
            last_src_ff <= src_ff;
            last_loc_ff <= loc_ff;
         end else if (upd_times) begin
            last_src_ff <= src_ff;
            last_loc_ff <= loc_paced;
         end else if (clr_times) begin
            last_src_ff <= '0;
            last_loc_ff <= '0;
         end
      end
   end

   // result register; drop payload on any status but sent
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= st;
         out_x_ff      <= (st == ST_SENT) ? x_ff : '0;
         out_y_ff      <= (st == ST_SENT) ? y_ff : '0;
         out_btn_ff    <= (st == ST_SENT) ? btn : BTN_NONE;
         out_delay_ff  <= (st == ST_SENT) ? dly : '0;
      end
   end

   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_button_code = out_btn_ff;
   assign rsp_delay_us    = out_delay_ff;
   assign rsp_status      = out_status_ff;

endmodule

@@ rtl/core/touch_slot_tracker_pacer_core.sv @@
// Touch slot tracker and pacer: turns touch down, move and up events into mouse
// events with a pacing delay, tracking up to SLOTS pointer ids. An event passes
// through a one-slot-per-cycle scan of the slot table, then the time offsets,
// the delay and the commit before its result turns valid. The block is ready
// again in the cycle the result appears, so it takes no new event before it is
// through with the last one. The result sits in an output register, so the next
// event is taken while it waits; the commit of that next event holds until the
// earlier result has been transferred. Every event yields exactly one result
// with a status.
// Depends on tstp_pkg, tstp_if, tstp_ctrl and tstp_datapath.
module touch_slot_tracker_pacer_core import tstp_pkg::*; #(
   parameter int SLOTS = 10
) (
   input logic        clock,
   input logic        reset,
   tstp_req_if.sink   req_chan,
   tstp_rsp_if.source rsp_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   tstp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   tstp_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_chan.func),
      .req_pointer_id  (req_chan.pointer_id),
      .req_pos_x       (req_chan.pos_x),
      .req_pos_y       (req_chan.pos_y),
      .req_source_time (req_chan.source_time),
      .req_local_time  (req_chan.local_time),
      .rsp_out_x       (rsp_chan.out_x),
      .rsp_out_y       (rsp_chan.out_y),
      .rsp_button_code (rsp_chan.button_code),
      .rsp_delay_us    (rsp_chan.delay_us),
      .rsp_status      (rsp_chan.status)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("commit did not raise result valid");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("ready stayed high while an event is in work");

   a_no_payload_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != ST_SENT) |->
         (rsp_chan.delay_us == '0) && (rsp_chan.button_code == BTN_NONE))
      else $error("payload present on a result that was not sent");

   a_commit_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_chan.valid || rsp_chan.ready)
      else $error("result overwritten before transfer");

endmodule
